// ===== rtl/thvr_pkg.sv =====
// shared types, codes and constants of the torch height velocity ramp
package thvr_pkg;

  // plasma mode codes
  localparam logic [2:0] MODE_OFF         = 3'd0;
  localparam logic [2:0] MODE_IGNITION    = 3'd1;
  localparam logic [2:0] MODE_ESTABLISHED = 3'd2;
  localparam logic [2:0] MODE_HEIGHT      = 3'd3;
  localparam logic [2:0] MODE_SLOWDOWN    = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_MAX_ACC       = 3'd0;
  localparam logic [2:0] CFG_RETRACT_STEPS = 3'd1;
  localparam logic [2:0] CFG_Z_TOP         = 3'd2;
  localparam logic [2:0] CFG_Z_BOTTOM      = 3'd3;
  localparam logic [2:0] CFG_STOP_DISTANCE = 3'd4;
  localparam logic [2:0] CFG_MAX_SPEED     = 3'd5;
  localparam logic [2:0] CFG_SQUARE_SPEED  = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int MODE_W      = 3;
  localparam int OUT_DATA_W  = 24;

  // period divider: 250000 / |speed|
  localparam int          DIV_STEPS   = 18;
  localparam int          DIV_CNT_W   = 5;
  localparam int          DIVISOR_W   = 15;
  localparam logic [17:0] PERIOD_NUMERATOR = 18'd250000;
  localparam logic [15:0] PERIOD_STOPPED   = 16'hFFFF;

  localparam logic [7:0]         OSC_RESTART_COUNT  = 8'd100;
  localparam logic signed [15:0] SQUARE_SPEED_RESET = 16'sd25000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TARGET,
    S_RAMP,
    S_START,
    S_DIV,
    S_DONE
  } thvr_state_t;

  typedef struct packed {
    logic latch_in;
    logic do_target;
    logic do_ramp;
    logic div_start;
    logic load_out;
  } thvr_cmd_t;

endpackage

// ===== rtl/torch_height_velocity_ramp_unit.sv =====
// top level of the torch height velocity ramp unit
//
// one input transfer per control tick carries the plasma mode (in_tuser) and
// the current z position with the oscillator restart flag (in_tdata); each
// tick gives exactly one result transfer with the step timer period, the
// direction and the status flags (out_tdata).
// configuration registers are written through cfg_we / cfg_index / cfg_data,
// one register per cycle; the user must write them only while no tick is in
// flight, which the block does not enforce. unknown indexes are dropped.
// the result shows on out_tvalid once the tick has passed the target, ramp,
// divider start, divide and done states; a new tick is taken only once the last
// one is in the output register. the 18-step serial divider forms 250000 / |speed|.
// the result sits in an output register, so the next tick is taken while a
// result still waits; if the receiver stalls longer than one tick, the block
// holds the finished tick and in_tready stays low until the output frees.
// reset (rst_n low, synchronous) clears the sequencer, empties the output,
// sets speed and target to zero, direction up, safe position zero and loads
// the oscillator with the reset square speed; registers take their reset
// values.
module torch_height_velocity_ramp_unit
  import thvr_pkg::*;
#(
  parameter int POSITION_WIDTH = 32,
  parameter int OSC_HALF_TICKS = 200
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // input channel
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // fields from bit 0: z_position, restart, zero fill
  input  logic [((POSITION_WIDTH + 1 + 7) / 8) * 8 - 1:0] in_tdata,
  // fields from bit 0: plasma_mode
  input  logic [MODE_W-1:0]                             in_tuser,
  // result channel
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // fields from bit 0: step_period, period_update, direction_up, single_step,
  // overrun_fault, at_safe_position, zero fill
  output logic [OUT_DATA_W-1:0]                         out_tdata,
  // configuration write port
  input  logic                                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]                        cfg_index,
  input  logic [CFG_DATA_W-1:0]                         cfg_data
);

  thvr_cmd_t   cmd;
  logic        div_done;
  logic [15:0] res_period;
  logic        res_update;
  logic        res_dir_up;
  logic        res_single_step;
  logic        res_fault;
  logic        res_at_safe;

  // sequencer: one tick at a time, output handshake kept here
  thvr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .div_done   (div_done),
    .cmd        (cmd)
  );

  // arithmetic, configuration and the held result
  thvr_datapath #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .OSC_HALF_TICKS (OSC_HALF_TICKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .div_done        (div_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_mode         (in_tuser),
    .in_z            (in_tdata[POSITION_WIDTH-1:0]),
    .in_restart      (in_tdata[POSITION_WIDTH]),
    .res_period      (res_period),
    .res_update      (res_update),
    .res_dir_up      (res_dir_up),
    .res_single_step (res_single_step),
    .res_fault       (res_fault),
    .res_at_safe     (res_at_safe)
  );

  assign out_tdata = {3'b000, res_at_safe, res_fault, res_single_step, res_dir_up,
                      res_update, res_period};

  // a tick in flight blocks the next input transfer
  a_one_tick_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a tick is in flight");

  // a single step only comes from rest: direction up, speed held at zero
  a_single_step_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[18]) |->
      (out_tdata[17] && !out_tdata[16] && (out_tdata[15:0] == PERIOD_STOPPED)))
    else $error("single step with the torch in motion");

  // overrun is a height control flag, single step a slowdown one
  a_fault_step_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[19] && out_tdata[18]))
    else $error("overrun and single step in the same tick");

endmodule

// ===== rtl/thvr_div.sv =====
// serial restoring divider for the step timer period
module thvr_div
  import thvr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [15:0]          period
);

  localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DIV_STEPS - 1);

  logic                   busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]   divisor_r, divisor_nxt;
  logic [DIVISOR_W-1:0]   rem_r, rem_nxt;
  logic [DIV_STEPS-1:0]   quo_r, quo_nxt;
  logic [DIVISOR_W:0]     rem_sh;
  logic [DIVISOR_W:0]     rem_sub;
  logic                   ge;
  logic [DIV_CNT_W-1:0]   bit_idx;

  assign bit_idx = LAST_CNT - cnt_r;
  assign rem_sh  = {rem_r, PERIOD_NUMERATOR[bit_idx]};
  assign ge      = rem_sh >= {1'b0, divisor_r};
  assign rem_sub = rem_sh - {1'b0, divisor_r};

  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    divisor_nxt = divisor_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    if (start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      divisor_nxt = divisor;
      rem_nxt     = '0;
      quo_nxt     = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIV_STEPS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    divisor_r <= divisor_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
  end

  // zero divisor gives an all-ones quotient, which saturates to stopped
  assign done   = busy_r && (cnt_r == LAST_CNT);
  assign period = (|quo_r[DIV_STEPS-1:16]) ? PERIOD_STOPPED : quo_r[15:0];

endmodule

// ===== rtl/thvr_datapath.sv =====
// datapath: configuration, target selection, speed ramp and result register
module thvr_datapath
  import thvr_pkg::*;
#(
  parameter int POSITION_WIDTH = 32,
  parameter int OSC_HALF_TICKS = 200
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  thvr_cmd_t                  cmd,
  output logic                       div_done,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic [POSITION_WIDTH-1:0]  in_z,
  input  logic                       in_restart,
  output logic [15:0]                res_period,
  output logic                       res_update,
  output logic                       res_dir_up,
  output logic                       res_single_step,
  output logic                       res_fault,
  output logic                       res_at_safe
);

  localparam int SUM_W = (POSITION_WIDTH > 31 ? POSITION_WIDTH : 31) + 2;
  localparam logic [7:0] OSC_HALF = 8'(OSC_HALF_TICKS);

  // configuration registers
  logic [14:0]                      max_acc_r;
  logic [30:0]                      retract_r;
  logic signed [POSITION_WIDTH-1:0] z_top_r;
  logic signed [POSITION_WIDTH-1:0] z_bottom_r;
  logic [15:0]                      stop_dist_r;
  logic [14:0]                      speed_limit_r;
  logic [14:0]                      square_r;

  // tick state
  logic signed [15:0]               speed_r, speed_nxt;
  logic signed [15:0]               target_r, target_nxt;
  logic                             dir_r, dir_nxt;
  logic signed [POSITION_WIDTH-1:0] safe_r, safe_nxt;
  logic signed [15:0]               osc_speed_r, osc_speed_nxt;
  logic [7:0]                       osc_count_r, osc_count_nxt;

  // latched input and per-tick flags
  logic [MODE_W-1:0]                mode_r, mode_nxt;
  logic signed [POSITION_WIDTH-1:0] z_r, z_nxt;
  logic                             restart_r, restart_nxt;
  logic                             fault_r, fault_nxt;
  logic                             step1_r, step1_nxt;
  logic                             upd_r, upd_nxt;
  logic                             at_safe_r, at_safe_nxt;

  // result register
  logic [15:0] o_period_r, o_period_nxt;
  logic        o_upd_r, o_upd_nxt;
  logic        o_dir_r, o_dir_nxt;
  logic        o_step_r, o_step_nxt;
  logic        o_fault_r, o_fault_nxt;
  logic        o_safe_r, o_safe_nxt;

  logic signed [SUM_W-1:0] z_ext, top_ext, safe_ext, retract_ext, stop_ext;
  logic signed [SUM_W-1:0] retract_sum, gap;
  logic signed [15:0]      osc_speed_v;
  logic [7:0]              osc_count_v;
  logic signed [16:0]      acc_raw, acc_lim, acc_clamp;
  logic signed [17:0]      sum_speed, ms_ext;
  logic signed [15:0]      speed_new;
  logic signed [15:0]      speed_neg;
  logic [DIVISOR_W-1:0]    speed_mag;
  logic [15:0]             div_period;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_acc_r     <= '0;
      retract_r     <= '0;
      z_top_r       <= '0;
      z_bottom_r    <= '0;
      stop_dist_r   <= 16'hFFFF;
      speed_limit_r <= 15'h7FFF;
      square_r      <= SQUARE_SPEED_RESET[14:0];
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ACC:       max_acc_r     <= cfg_data[14:0];
        CFG_RETRACT_STEPS: retract_r     <= cfg_data[30:0];
        CFG_Z_TOP:         z_top_r       <= cfg_data[POSITION_WIDTH-1:0];
        CFG_Z_BOTTOM:      z_bottom_r    <= cfg_data[POSITION_WIDTH-1:0];
        CFG_STOP_DISTANCE: stop_dist_r   <= cfg_data[15:0];
        CFG_MAX_SPEED:     speed_limit_r <= cfg_data[14:0];
        CFG_SQUARE_SPEED:  square_r      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign z_ext       = $signed({{(SUM_W-POSITION_WIDTH){z_r[POSITION_WIDTH-1]}}, z_r});
  assign top_ext     = $signed({{(SUM_W-POSITION_WIDTH){z_top_r[POSITION_WIDTH-1]}}, z_top_r});
  assign safe_ext    = $signed({{(SUM_W-POSITION_WIDTH){safe_r[POSITION_WIDTH-1]}}, safe_r});
  assign retract_ext = $signed({{(SUM_W-31){1'b0}}, retract_r});
  assign stop_ext    = $signed({{(SUM_W-16){1'b0}}, stop_dist_r});
  assign retract_sum = z_ext + retract_ext;
  assign gap         = safe_ext - z_ext;

  assign osc_speed_v = restart_r ? $signed({1'b0, square_r}) : osc_speed_r;
  assign osc_count_v = restart_r ? OSC_RESTART_COUNT : osc_count_r;

  // ramp: limit the change, then clamp the speed
  assign acc_raw = $signed({target_r[15], target_r}) - $signed({speed_r[15], speed_r});
  assign acc_lim = $signed({2'b00, max_acc_r});
  always_comb begin
    if (acc_raw > acc_lim) begin
      acc_clamp = acc_lim;
    end else if (acc_raw < -acc_lim) begin
      acc_clamp = -acc_lim;
    end else begin
      acc_clamp = acc_raw;
    end
  end
  assign sum_speed = $signed({{2{speed_r[15]}}, speed_r}) + $signed({acc_clamp[16], acc_clamp});
  assign ms_ext    = $signed({3'b000, speed_limit_r});
  always_comb begin
    if (sum_speed > ms_ext) begin
      speed_new = $signed({1'b0, speed_limit_r});
    end else if (sum_speed < -ms_ext) begin
      speed_new = -$signed({1'b0, speed_limit_r});
    end else begin
      speed_new = sum_speed[15:0];
    end
  end

  assign speed_neg = -speed_r;
  assign speed_mag = speed_r[15] ? speed_neg[DIVISOR_W-1:0] : speed_r[DIVISOR_W-1:0];

  always_comb begin
    speed_nxt     = speed_r;
    target_nxt    = target_r;
    dir_nxt       = dir_r;
    safe_nxt      = safe_r;
    osc_speed_nxt = osc_speed_r;
    osc_count_nxt = osc_count_r;
    mode_nxt      = mode_r;
    z_nxt         = z_r;
    restart_nxt   = restart_r;
    fault_nxt     = fault_r;
    step1_nxt     = step1_r;
    upd_nxt       = upd_r;
    at_safe_nxt   = at_safe_r;
    o_period_nxt  = o_period_r;
    o_upd_nxt     = o_upd_r;
    o_dir_nxt     = o_dir_r;
    o_step_nxt    = o_step_r;
    o_fault_nxt   = o_fault_r;
    o_safe_nxt    = o_safe_r;

    if (cmd.latch_in) begin
      mode_nxt    = in_mode;
      z_nxt       = in_z;
      restart_nxt = in_restart;
    end

    if (cmd.do_target) begin
      fault_nxt     = 1'b0;
      step1_nxt     = 1'b0;
      osc_speed_nxt = osc_speed_v;
      osc_count_nxt = osc_count_v;
      case (mode_r)
        MODE_OFF, MODE_IGNITION, MODE_ESTABLISHED: begin
          target_nxt = '0;
        end
        MODE_HEIGHT: begin
          fault_nxt = (z_r > z_top_r) || (z_r < z_bottom_r);
          if (osc_count_v == OSC_HALF) begin
            osc_count_nxt = '0;
            osc_speed_nxt = -osc_speed_v;
            target_nxt    = -osc_speed_v;
          end else begin
            osc_count_nxt = osc_count_v + 8'd1;
            target_nxt    = osc_speed_v;
          end
          safe_nxt = (retract_sum < top_ext) ? retract_sum[POSITION_WIDTH-1:0] : z_top_r;
        end
        MODE_SLOWDOWN: begin
          if (z_r < safe_r) begin
            if (gap > stop_ext) begin
              target_nxt = $signed({1'b0, speed_limit_r});
            end else begin
              target_nxt = '0;
              if (speed_r == '0) begin
                dir_nxt   = 1'b1;
                step1_nxt = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd.do_ramp) begin
      at_safe_nxt = (z_r == safe_r);
      upd_nxt     = 1'b0;
      if (acc_raw != '0) begin
        speed_nxt = speed_new;
        dir_nxt   = !speed_new[15];
        upd_nxt   = 1'b1;
      end
    end

    if (cmd.load_out) begin
      o_period_nxt = div_period;
      o_upd_nxt    = upd_r;
      o_dir_nxt    = dir_r;
      o_step_nxt   = step1_r;
      o_fault_nxt  = fault_r;
      o_safe_nxt   = at_safe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= '0;
      target_r    <= '0;
      dir_r       <= 1'b1;
      safe_r      <= '0;
      osc_speed_r <= SQUARE_SPEED_RESET;
      osc_count_r <= '0;
    end else begin
      speed_r     <= speed_nxt;
      target_r    <= target_nxt;
      dir_r       <= dir_nxt;
      safe_r      <= safe_nxt;
      osc_speed_r <= osc_speed_nxt;
      osc_count_r <= osc_count_nxt;
    end
    mode_r     <= mode_nxt;
    z_r        <= z_nxt;
    restart_r  <= restart_nxt;
    fault_r    <= fault_nxt;
    step1_r    <= step1_nxt;
    upd_r      <= upd_nxt;
    at_safe_r  <= at_safe_nxt;
    o_period_r <= o_period_nxt;
    o_upd_r    <= o_upd_nxt;
    o_dir_r    <= o_dir_nxt;
    o_step_r   <= o_step_nxt;
    o_fault_r  <= o_fault_nxt;
    o_safe_r   <= o_safe_nxt;
  end

  thvr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (speed_mag),
    .done    (div_done),
    .period  (div_period)
  );

  assign res_period      = o_period_r;
  assign res_update      = o_upd_r;
  assign res_dir_up      = o_dir_r;
  assign res_single_step = o_step_r;
  assign res_fault       = o_fault_r;
  assign res_at_safe     = o_safe_r;

endmodule

// ===== rtl/thvr_ctrl.sv =====
// controller: sequences one tick through target, ramp, divide and result
module thvr_ctrl
  import thvr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  logic      div_done,
  output thvr_cmd_t cmd
);

  thvr_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_TARGET;
      S_TARGET: state_nxt = S_RAMP;
      S_RAMP:   state_nxt = S_START;
      S_START:  state_nxt = S_DIV;
      S_DIV:    if (div_done) state_nxt = S_DONE;
      S_DONE:   if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        cmd.latch_in = in_tvalid;
      end
      S_TARGET: cmd.do_target = 1'b1;
      S_RAMP:   cmd.do_ramp   = 1'b1;
      S_START:  cmd.div_start = 1'b1;
      S_DONE:   cmd.load_out  = slot_free;
      default: ;
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== tb/sv/thvr_ramp_checker.sv =====
`timescale 1ns / 100ps
// checker for the torch height velocity ramp: predicts every tick result and compares it
module thvr_ramp_checker
  import thvr_pkg::*;
#(
  parameter int OSC_HALF_TICKS = 200
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // fields from bit 0: z_position, restart, zero fill
  input  logic [39:0]            in_tdata,
  // fields from bit 0: plasma_mode
  input  logic [MODE_W-1:0]      in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // fields from bit 0: step_period, period_update, direction_up, single_step,
  // overrun_fault, at_safe_position, zero fill
  input  logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending_ticks,
  output int                     results_checked
);

  typedef struct packed {
    logic        at_safe_position;
    logic        overrun_fault;
    logic        single_step;
    logic        direction_up;
    logic        period_update;
    logic [15:0] step_period;
  } tick_result_t;

  // register copies
  logic [14:0]        max_acc;
  logic [30:0]        retract_steps;
  logic signed [31:0] z_top;
  logic signed [31:0] z_bottom;
  logic [15:0]        stop_distance;
  logic [14:0]        speed_limit;
  logic [14:0]        square_speed;

  // ramp state
  logic signed [15:0] speed;
  logic signed [15:0] target_speed;
  logic               dir_up;
  logic signed [31:0] safe_position;
  logic signed [15:0] osc_speed;
  logic [7:0]         osc_count;

  tick_result_t queued_tick_results[$];
  int           fails = 0;
  int           checked = 0;

  function automatic tick_result_t ramp_tick(input logic [2:0] mode,
                                             input logic signed [31:0] z,
                                             input logic restart);
    tick_result_t r;
    int           delta;
    int           next_speed;
    int           mag;
    int           quot;
    longint       reach;
    r = '0;
    if (restart) begin
      osc_speed = $signed({1'b0, square_speed});
      osc_count = OSC_RESTART_COUNT;
    end
    case (mode)
      MODE_OFF, MODE_IGNITION, MODE_ESTABLISHED: target_speed = '0;
      MODE_HEIGHT: begin
        r.overrun_fault = (z > z_top) || (z < z_bottom);
        if (osc_count == 8'(OSC_HALF_TICKS)) begin
          osc_count = '0;
          osc_speed = -osc_speed;
        end else begin
          osc_count = osc_count + 8'd1;
        end
        target_speed  = osc_speed;
        reach         = longint'(z) + longint'(retract_steps);
        safe_position = (reach < longint'(z_top)) ? 32'(reach) : z_top;
      end
      MODE_SLOWDOWN: begin
        if (z < safe_position) begin
          if (longint'(safe_position) - longint'(z) > longint'(stop_distance)) begin
            target_speed = $signed({1'b0, speed_limit});
          end else begin
            target_speed = '0;
            if (speed == 0) begin
              dir_up        = 1'b1;
              r.single_step = 1'b1;
            end
          end
        end
      end
      default: ; // unused modes hold the target
    endcase

    delta = int'(target_speed) - int'(speed);
    if (delta != 0) begin
      if (delta > int'(max_acc))
        delta = int'(max_acc);
      else if (delta < -int'(max_acc))
        delta = -int'(max_acc);
      next_speed = int'(speed) + delta;
      if (next_speed > int'(speed_limit))
        next_speed = int'(speed_limit);
      else if (next_speed < -int'(speed_limit))
        next_speed = -int'(speed_limit);
      speed           = 16'(next_speed);
      dir_up          = next_speed >= 0;
      r.period_update = 1'b1;
    end

    mag = (speed < 0) ? -int'(speed) : int'(speed);
    if (mag == 0) begin
      r.step_period = PERIOD_STOPPED;
    end else begin
      quot = int'(PERIOD_NUMERATOR) / mag;
      r.step_period = (quot > int'(PERIOD_STOPPED)) ? PERIOD_STOPPED : 16'(quot);
    end
    r.direction_up     = dir_up;
    r.at_safe_position = (z == safe_position);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    if (!rst_n) begin
      max_acc       = '0;
      retract_steps = '0;
      z_top         = '0;
      z_bottom      = '0;
      stop_distance = 16'hFFFF;
      speed_limit   = 15'h7FFF;
      square_speed  = SQUARE_SPEED_RESET[14:0];
      speed         = '0;
      target_speed  = '0;
      dir_up        = 1'b1;
      safe_position = '0;
      osc_speed     = SQUARE_SPEED_RESET;
      osc_count     = '0;
      queued_tick_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_ACC:       max_acc       = cfg_data[14:0];
          CFG_RETRACT_STEPS: retract_steps = cfg_data[30:0];
          CFG_Z_TOP:         z_top         = cfg_data;
          CFG_Z_BOTTOM:      z_bottom      = cfg_data;
          CFG_STOP_DISTANCE: stop_distance = cfg_data[15:0];
          CFG_MAX_SPEED:     speed_limit   = cfg_data[14:0];
          CFG_SQUARE_SPEED:  square_speed  = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        queued_tick_results.push_back(ramp_tick(in_tuser, in_tdata[31:0], in_tdata[32]));
      if (out_tvalid && out_tready) begin
        if (queued_tick_results.size() == 0) begin
          $display("%0t: result transfer with no tick pending, actual %h", $time, out_tdata);
          fails++;
        end else begin
          want = queued_tick_results.pop_front();
          got  = tick_result_t'(out_tdata[20:0]);
          check_field("step_period", 32'(want.step_period), 32'(got.step_period));
          check_field("period_update", 32'(want.period_update), 32'(got.period_update));
          check_field("direction_up", 32'(want.direction_up), 32'(got.direction_up));
          check_field("single_step", 32'(want.single_step), 32'(got.single_step));
          check_field("overrun_fault", 32'(want.overrun_fault), 32'(got.overrun_fault));
          check_field("at_safe_position", 32'(want.at_safe_position),
                      32'(got.at_safe_position));
          checked++;
        end
      end
    end
    pending_ticks   <= queued_tick_results.size();
    fail_count      <= fails;
    results_checked <= checked;
  end

endmodule

// ===== tb/sv/torch_height_velocity_ramp_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the torch height velocity ramp unit: stimulus, idling and verdict
module torch_height_velocity_ramp_unit_tb;
  import thvr_pkg::*;

  localparam int          CYCLE_LIMIT      = 1_000_000;
  localparam int          DRAIN_CYCLES     = 30;   // idle wait before the verdict
  localparam int          PHASE_TICKS      = 110;
  localparam int          RANDOM_PHASES    = 6;
  localparam logic [2:0]  CFG_UNUSED_INDEX = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SHORT,
    STALL_LONG
  } stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // fields from bit 0: z_position, restart, zero fill
  logic [39:0]            in_tdata = '0;
  // fields from bit 0: plasma_mode
  logic [MODE_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // fields from bit 0: step_period, period_update, direction_up, single_step,
  // overrun_fault, at_safe_position, zero fill
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending_ticks;
  int results_checked;

  int          cycle_count = 0;
  int          ticks_sent = 0;
  int          burst_left = 0;
  int          settings_count = 0;
  logic [31:0] reg_plan [7];

  stall_mode_t stall_style = STALL_NONE;
  int          style_left = 0;
  int          stall_left = 0;

  always #5 clk = ~clk;

  torch_height_velocity_ramp_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  thvr_ramp_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_ticks  (pending_ticks),
    .results_checked(results_checked)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // hard stop in case the block hangs or loses a result
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d ticks still pending", cycle_count, pending_ticks);
    $display("Test completed with failures");
    $finish;
  end

  // receiver: switches between no stalls, frequent short stalls and rare long
  // stalls; long stalls can exceed one tick so the output register backs up
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= stall_mode_t'($urandom_range(0, 2));
      style_left  <= $urandom_range(100, 600);
    end else begin
      style_left <= style_left - 1;
    end
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      case (stall_style)
        STALL_SHORT: if ($urandom_range(0, 1) == 0) stall_left <= $urandom_range(1, 3);
        STALL_LONG:  if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(10, 40);
        default: ;
      endcase
    end
  end

  // one tick transfer; bursts of random length, random gaps after each burst
  task automatic send_tick(input logic [2:0] mode, input logic [31:0] z,
                           input logic restart);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'd0, restart, z};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait until every tick result has been taken
  task automatic drain_ticks;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ticks != 0) @(posedge clk);
  endtask

  task automatic set_plan(input logic [31:0] acc, input logic [31:0] retract,
                          input logic [31:0] top, input logic [31:0] bottom,
                          input logic [31:0] stop, input logic [31:0] max_spd,
                          input logic [31:0] square);
    reg_plan[CFG_MAX_ACC]       = acc;
    reg_plan[CFG_RETRACT_STEPS] = retract;
    reg_plan[CFG_Z_TOP]         = top;
    reg_plan[CFG_Z_BOTTOM]      = bottom;
    reg_plan[CFG_STOP_DISTANCE] = stop;
    reg_plan[CFG_MAX_SPEED]     = max_spd;
    reg_plan[CFG_SQUARE_SPEED]  = square;
  endtask

  // writes every register of the plan, then a junk write to an unused index
  task automatic program_regs;
    for (int i = 0; i <= int'(CFG_SQUARE_SPEED); i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= reg_plan[i];
      @(posedge clk);
    end
    cfg_index <= CFG_UNUSED_INDEX;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // a plausible cut: start-up modes, height control wandering around a
  // center, then slowdown climbing toward the safe position, then off
  task automatic run_cut_cycle;
    longint top_l;
    longint bottom_l;
    longint z;
    longint safe;
    longint stop;
    int     height_ticks;
    int     slow_ticks;
    logic   restart;
    top_l    = longint'($signed(reg_plan[CFG_Z_TOP]));
    bottom_l = longint'($signed(reg_plan[CFG_Z_BOTTOM]));
    stop     = longint'(reg_plan[CFG_STOP_DISTANCE]);
    if (top_l >= bottom_l)
      z = bottom_l + longint'($urandom) % (top_l - bottom_l + 1);
    else
      z = longint'($signed($urandom));
    repeat ($urandom_range(1, 3)) send_tick(MODE_OFF, 32'(z), $urandom_range(0, 31) == 0);
    repeat ($urandom_range(1, 3)) send_tick(MODE_IGNITION, 32'(z), 1'b0);
    repeat ($urandom_range(1, 3)) send_tick(MODE_ESTABLISHED, 32'(z), 1'b0);

    // long runs now and then so the square wave flips sign
    height_ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 420)
                                                : $urandom_range(5, 60);
    for (int t = 0; t < height_ticks; t++) begin
      case ($urandom_range(0, 19))
        0:       z = top_l + $urandom_range(0, 100);
        1:       z = bottom_l - $urandom_range(0, 100);
        default: z = z + longint'(int'($urandom_range(0, 80))) - 40;
      endcase
      z = longint'($signed(32'(z)));
      restart = (t == 0) ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 63) == 0);
      send_tick(MODE_HEIGHT, 32'(z), restart);
    end

    safe = z + longint'(reg_plan[CFG_RETRACT_STEPS]);
    if (safe > top_l) safe = top_l;
    slow_ticks = $urandom_range(3, 40);
    repeat (slow_ticks) begin
      case ($urandom_range(0, 3))
        0:       z = safe - longint'($urandom_range(0, 32'(stop) + 10));
        1:       z = safe;
        default: z = z + $urandom_range(0, 200);
      endcase
      z = longint'($signed(32'(z)));
      send_tick(MODE_SLOWDOWN, 32'(z), $urandom_range(0, 31) == 0);
    end
    repeat ($urandom_range(1, 5)) send_tick(MODE_OFF, 32'(z), 1'b0);
  endtask

  initial begin
    int phase_start;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full acceleration so each tick lands on its target
    set_plan(32'd32767, 32'd500, 32'd10000, -32'sd10000, 32'd100, 32'd32767, 32'd25000);
    program_regs();
    send_tick(MODE_OFF, 32'd0, 1'b0);
    send_tick(MODE_IGNITION, 32'h7FFF_FFFF, 1'b0);
    send_tick(MODE_ESTABLISHED, 32'h8000_0000, 1'b0);
    send_tick(MODE_HEIGHT, 32'd0, 1'b1);             // oscillator restart
    send_tick(MODE_HEIGHT, 32'd20000, 1'b0);         // overrun above top
    send_tick(MODE_HEIGHT, -32'sd20000, 1'b0);       // overrun below bottom
    send_tick(MODE_HEIGHT, 32'h7FFF_FFFF, 1'b0);     // retract reach past 32 bits
    send_tick(MODE_HEIGHT, 32'h8000_0000, 1'b0);
    send_tick(3'd5, 32'd77, 1'b0);                   // unused modes keep the target
    send_tick(3'd6, 32'hFFFF_FFFF, 1'b0);
    send_tick(3'd7, 32'd0, 1'b1);
    send_tick(MODE_HEIGHT, 32'd1000, 1'b0);          // safe position 1500
    send_tick(MODE_SLOWDOWN, 32'd1500, 1'b0);        // at the safe position
    send_tick(MODE_SLOWDOWN, 32'd2000, 1'b0);        // above the safe position
    send_tick(MODE_SLOWDOWN, 32'd0, 1'b0);           // far: full approach speed
    send_tick(MODE_SLOWDOWN, 32'd1450, 1'b0);        // close while moving
    send_tick(MODE_SLOWDOWN, 32'd1450, 1'b0);        // close and stopped: single step
    send_tick(MODE_SLOWDOWN, 32'd1450, 1'b0);        // speed already at target
    send_tick(MODE_OFF, 32'd1450, 1'b0);
    drain_ticks();

    // zero speed clamp with the largest square wave
    set_plan(32'd32767, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd32767);
    program_regs();
    send_tick(MODE_HEIGHT, 32'd0, 1'b1);
    send_tick(MODE_HEIGHT, 32'd0, 1'b0);
    drain_ticks();

    // zero acceleration: speed never moves
    set_plan(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd32767, 32'd25000);
    program_regs();
    send_tick(MODE_HEIGHT, 32'd5, 1'b0);
    send_tick(MODE_OFF, 32'd5, 1'b0);
    drain_ticks();

    // random phases: first the high extremes, then the low ones, then mixes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_plan(32'd32767, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'd65535, 32'd32767, 32'd32767);
        1: set_plan(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0);
        default: set_plan($urandom_range(1, 4000), $urandom_range(0, 5000),
                          $urandom_range(0, 200000), -$urandom_range(0, 200000),
                          $urandom_range(0, 2000), $urandom_range(1, 32767),
                          $urandom_range(0, 32767));
      endcase
      program_regs();
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) begin
        if ($urandom_range(0, 99) < 80)
          run_cut_cycle();
        else
          repeat ($urandom_range(1, 10))
            send_tick(3'($urandom_range(0, 7)), 32'($urandom), 1'($urandom_range(0, 1)));
      end
      drain_ticks();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d ticks over %0d register settings: all modes, restarts, overruns,",
             ticks_sent, settings_count);
    $display("slowdown approaches and single steps; %0d results checked", results_checked);
    if (fail_count == 0 && pending_ticks == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/thvr_pkg.sv
rtl/thvr_div.sv
rtl/thvr_datapath.sv
rtl/thvr_ctrl.sv
rtl/torch_height_velocity_ramp_unit.sv
tb/sv/thvr_ramp_checker.sv
tb/sv/torch_height_velocity_ramp_unit_tb.sv
